[rtl/totp_hmac_sha1_top_macros.svh]
// Assertion macros for the TOTP HMAC-SHA1 block.
// Used by totp_hmac_sha1_top; expects clk and rst_n in scope.
`ifndef TOTP_HMAC_SHA1_TOP_MACROS_SVH
`define TOTP_HMAC_SHA1_TOP_MACROS_SVH

// same-cycle implication
`define TOTP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TOTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/totp_pkg.sv]
// Shared types, constants and helpers for the TOTP HMAC-SHA1 block.
// No dependencies.
package totp_pkg;

  localparam int unsigned KEY_WORDS = 8;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned BLK_W     = 512;
  localparam int unsigned DIG_W     = 160;
  localparam int unsigned DIV_W     = 64;
  localparam int unsigned DVSR_W    = 20;
  localparam int unsigned CODE_W    = 20;

  localparam logic [DVSR_W-1:0] CODE_MOD = 20'd1000000;

  // v / 1000000 == (v * CODE_RECIP) >> CODE_SHIFT for any 31-bit v
  localparam logic [31:0] CODE_RECIP = 32'h8637BD06;
  localparam int unsigned CODE_SHIFT = 51;

  // last busy step of each divider operation
  localparam logic [2:0] DIV_STEP_LAST = 3'd6;
  localparam logic [2:0] DIV_CODE_LAST = 3'd1;

  localparam logic [7:0] IPAD_BYTE = 8'h36;
  localparam logic [7:0] OPAD_BYTE = 8'h5c;

  localparam logic [DIG_W-1:0] SHA_INIT = {
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // message bit lengths of the second blocks
  localparam logic [63:0] INNER_LEN = 64'd576;
  localparam logic [63:0] OUTER_LEN = 64'd672;

  typedef logic [BLK_W-1:0] blk_t;
  typedef logic [DIG_W-1:0] dig_t;

  typedef enum logic [1:0] {
    SHA_IDLE,
    SHA_RUN,
    SHA_FIN
  } sha_st_t;

  typedef enum logic [3:0] {
    T_IDLE,
    T_DIV,
    T_DIVW,
    T_INN1,
    T_INN1W,
    T_INN2,
    T_INN2W,
    T_OUT1,
    T_OUT1W,
    T_OUT2,
    T_OUT2W,
    T_TRUNC,
    T_MOD,
    T_MODW,
    T_EMIT
  } top_st_t;

  // divider operations: seconds / 30, code mod 1000000
  typedef enum logic {
    DIV_STEP,
    DIV_CODE
  } div_op_t;

  typedef struct packed {
    logic start;
    blk_t block;
    dig_t h_in;
  } sha_req_t;

  typedef struct packed {
    logic done;
    dig_t h_out;
  } sha_rsp_t;

  typedef struct packed {
    logic             start;
    div_op_t          op;
    logic [DIV_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_W-1:0]  quot;
    logic [DVSR_W-1:0] rem;
  } div_rsp_t;

  function automatic logic [31:0] sha_k(input logic [6:0] rnd);
    logic [31:0] k;
    if (rnd < 7'd20) k = 32'h5A827999;
    else if (rnd < 7'd40) k = 32'h6ED9EBA1;
    else if (rnd < 7'd60) k = 32'h8F1BBCDC;
    else k = 32'hCA62C1D6;
    return k;
  endfunction

endpackage

[rtl/totp_sha1_core.sv]
// Iterative SHA-1 compression, one round per cycle.
// Depends on totp_pkg.
module totp_sha1_core
  import totp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  sha_req_t req,
  output sha_rsp_t rsp
);

  sha_st_t     st_r, st_nxt;
  logic [6:0]  rnd_r;
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] win_r [16];
  dig_t        base_r;
  dig_t        hout_r;
  logic        done_r;
  logic [31:0] f, t, wnew;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      SHA_IDLE: if (req.start) st_nxt = SHA_RUN;
      SHA_RUN:  if (rnd_r == 7'd79) st_nxt = SHA_FIN;
      SHA_FIN:  st_nxt = SHA_IDLE;
      default:  st_nxt = SHA_IDLE;
    endcase
  end

  always_comb begin
    if (rnd_r < 7'd20) f = (b_r & c_r) | (~b_r & d_r);
    else if (rnd_r < 7'd40) f = b_r ^ c_r ^ d_r;
    else if (rnd_r < 7'd60) f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
    else f = b_r ^ c_r ^ d_r;
    t    = {a_r[26:0], a_r[31:27]} + f + e_r + sha_k(rnd_r) + win_r[0];
    wnew = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= SHA_IDLE;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == SHA_FIN);
      if (st_r == SHA_RUN) rnd_r <= rnd_r + 7'd1;
      else rnd_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == SHA_IDLE && req.start) begin
      base_r <= req.h_in;
      {a_r, b_r, c_r, d_r, e_r} <= req.h_in;
      for (int i = 0; i < 16; i++) win_r[i] <= req.block[BLK_W-1-32*i -: 32];
    end else if (st_r == SHA_RUN) begin
      a_r <= t;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
      for (int i = 0; i < 15; i++) win_r[i] <= win_r[i+1];
      win_r[15] <= {wnew[30:0], wnew[31]};
    end
    if (st_r == SHA_FIN) begin
      hout_r <= {base_r[159:128] + a_r, base_r[127:96] + b_r, base_r[95:64] + c_r,
                 base_r[63:32] + d_r, base_r[31:0] + e_r};
    end
  end

  assign rsp.done  = done_r;
  assign rsp.h_out = hout_r;

endmodule

[rtl/totp_divmod.sv]
// Constant divider: time step (x / 30) and code reduction (v mod 1000000).
// Shared by the top sequencer, one request at a time. Depends on totp_pkg.
module totp_divmod
  import totp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r, done_r;
  logic [2:0]        step_r;
  div_op_t           op_r;
  logic [DIV_W-1:0]  acc_r;
  logic [7:0]        nsum_r;
  logic [30:0]       val_r;
  logic [DIV_W-1:0]  quot_r;
  logic [DVSR_W-1:0] rem_r;
  logic              last;
  logic [7:0]        nsum;
  logic [4:0]        fold;
  logic [3:0]        mod15;
  logic [DIV_W-1:0]  spread;
  logic [62:0]       prod;
  logic [11:0]       qd;
  logic [31:0]       qm, rem_full;

  assign last = (op_r == DIV_STEP) ? (step_r == DIV_STEP_LAST) : (step_r == DIV_CODE_LAST);

  // x / 30 = (x >> 1) / 15: nibble sum gives the remainder mod 15, then the
  // exact quotient is (z - r) * inverse of 15, i.e. -(z - r) * 0x1111...1
  always_comb begin
    nsum = '0;
    for (int i = 0; i < 16; i++) nsum = nsum + {4'b0, acc_r[4*i +: 4]};
    fold = {1'b0, nsum_r[7:4]} + {1'b0, nsum_r[3:0]};
    if (fold >= 5'd30) mod15 = 4'd0;
    else if (fold >= 5'd15) mod15 = 4'(fold - 5'd15);
    else mod15 = fold[3:0];
    unique case (step_r)
      3'd2:    spread = {acc_r[DIV_W-5:0], 4'b0};
      3'd3:    spread = {acc_r[DIV_W-9:0], 8'b0};
      3'd4:    spread = {acc_r[DIV_W-17:0], 16'b0};
      3'd5:    spread = {acc_r[DIV_W-33:0], 32'b0};
      default: spread = '0;
    endcase
  end

  // code reduction by reciprocal multiply, then a subtract for the remainder
  assign prod     = 63'(val_r) * 63'(CODE_RECIP);
  assign qd       = acc_r[CODE_SHIFT +: 12];
  assign qm       = {20'b0, qd} * {12'b0, CODE_MOD};
  assign rem_full = {1'b0, val_r} - qm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r && req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 3'd1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && req.start) begin
      op_r  <= req.op;
      acc_r <= {1'b0, req.dividend[DIV_W-1:1]};
      val_r <= req.dividend[30:0];
    end else if (busy_r) begin
      if (op_r == DIV_STEP) begin
        unique case (step_r)
          3'd0:    nsum_r <= nsum;
          3'd1:    acc_r  <= acc_r - {{(DIV_W-4){1'b0}}, mod15};
          3'd6:    quot_r <= '0 - acc_r;
          default: acc_r  <= acc_r + spread;
        endcase
      end else begin
        if (step_r == 3'd0) acc_r <= {1'b0, prod};
        else rem_r <= rem_full[DVSR_W-1:0];
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

endmodule

[rtl/totp_hmac_sha1_top.sv]
// TOTP HMAC-SHA1 six-digit code generator, top level.
// Each input beat runs the divider (time step), four SHA-1 passes, truncation
// and the divider (code reduction); no new beat is taken before T_IDLE, and
// a stalled output register holds the block in T_EMIT and the next input off.
// Reset (rst_n low, synchronous) clears the key to zero and empties the pipe.
// Depends on totp_pkg, totp_sha1_core, totp_divmod and the macros header.
`include "totp_hmac_sha1_top_macros.svh"

module totp_hmac_sha1_top
  import totp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [63:0]          in_unix_seconds,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CODE_W-1:0]    out_otp_code,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  top_st_t st_r, st_nxt;

  logic [63:0]       key_r [KEY_WORDS];
  logic [63:0]       secs_r;
  logic [63:0]       step_r;      // time step counter
  dig_t              h_r;         // chaining value / final digest
  dig_t              inner_r;     // inner hash result
  logic [30:0]       trunc_r;
  logic              out_valid_r;
  logic [CODE_W-1:0] code_r;

  blk_t     key_blk;
  sha_req_t sha_req;
  sha_rsp_t sha_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     emit;
  logic [31:0] dyn_word;

  // key words packed big-endian, word 0 on top
  always_comb begin
    for (int i = 0; i < KEY_WORDS; i++) key_blk[BLK_W-1-64*i -: 64] = key_r[i];
  end

  // config: always ready, out-of-range index dropped
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_WORDS; i++) key_r[i] <= '0;
    end else if (cfg_valid && cfg_index < CFG_IDX_W'(KEY_WORDS)) begin
      key_r[cfg_index[2:0]] <= cfg_data;
    end
  end

  totp_sha1_core u_sha (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sha_req),
    .rsp   (sha_rsp)
  );

  totp_divmod u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign emit = (st_r == T_EMIT) && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      T_IDLE:  if (in_valid) st_nxt = T_DIV;
      T_DIV:   st_nxt = T_DIVW;
      T_DIVW:  if (div_rsp.done) st_nxt = T_INN1;
      T_INN1:  st_nxt = T_INN1W;
      T_INN1W: if (sha_rsp.done) st_nxt = T_INN2;
      T_INN2:  st_nxt = T_INN2W;
      T_INN2W: if (sha_rsp.done) st_nxt = T_OUT1;
      T_OUT1:  st_nxt = T_OUT1W;
      T_OUT1W: if (sha_rsp.done) st_nxt = T_OUT2;
      T_OUT2:  st_nxt = T_OUT2W;
      T_OUT2W: if (sha_rsp.done) st_nxt = T_TRUNC;
      T_TRUNC: st_nxt = T_MOD;
      T_MOD:   st_nxt = T_MODW;
      T_MODW:  if (div_rsp.done) st_nxt = T_EMIT;
      T_EMIT:  if (emit) st_nxt = T_IDLE;
      default: st_nxt = T_IDLE;
    endcase
  end

  // unit requests
  always_comb begin
    in_ready         = (st_r == T_IDLE);
    sha_req.start    = 1'b0;
    sha_req.block    = key_blk ^ {64{IPAD_BYTE}};
    sha_req.h_in     = SHA_INIT;
    div_req.start    = 1'b0;
    div_req.op       = DIV_STEP;
    div_req.dividend = secs_r;
    unique case (st_r)
      T_DIV: div_req.start = 1'b1;
      T_INN1: sha_req.start = 1'b1;
      T_INN2: begin
        sha_req.start = 1'b1;
        sha_req.block = {step_r, 8'h80, 376'b0, INNER_LEN};
        sha_req.h_in  = h_r;
      end
      T_OUT1: begin
        sha_req.start = 1'b1;
        sha_req.block = key_blk ^ {64{OPAD_BYTE}};
      end
      T_OUT2: begin
        sha_req.start = 1'b1;
        sha_req.block = {inner_r, 8'h80, 280'b0, OUTER_LEN};
        sha_req.h_in  = h_r;
      end
      T_MOD: begin
        div_req.start    = 1'b1;
        div_req.op       = DIV_CODE;
        div_req.dividend = {33'b0, trunc_r};
      end
      default: ;
    endcase
  end

  // dynamic truncation: offset from low nibble of the last digest byte
  assign dyn_word = h_r[(DIG_W-1) - 8*h_r[3:0] -: 32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == T_IDLE && in_valid) secs_r <= in_unix_seconds;
    if (st_r == T_DIVW && div_rsp.done) step_r <= div_rsp.quot;
    if ((st_r == T_INN1W || st_r == T_OUT1W || st_r == T_OUT2W) && sha_rsp.done)
      h_r <= sha_rsp.h_out;
    if (st_r == T_INN2W && sha_rsp.done) inner_r <= sha_rsp.h_out;
    if (st_r == T_TRUNC) trunc_r <= dyn_word[30:0];
    if (emit) code_r <= div_rsp.rem;
  end

  assign out_valid    = out_valid_r;
  assign out_otp_code = code_r;

  `TOTP_ASSERT_NEXT(a_leave_idle, in_valid && in_ready, st_r == T_DIV, "beat not started")
  `TOTP_ASSERT_NOW(a_code_range, out_valid, out_otp_code < CODE_MOD, "code out of range")
  `TOTP_ASSERT_NEXT(a_emit_valid, emit, out_valid && st_r == T_IDLE, "emit lost result")

endmodule
